[rtl/tgs_pkg.sv]
`timescale 1ns / 1ps
package tgs_pkg;
   localparam int TableDepth  = 64;
   localparam int SensorCount = 16;
   localparam int IdxW        = $clog2(TableDepth);
   localparam int CntW        = $clog2(TableDepth + 1);
   localparam int SenW        = 4;
   localparam int SenCntW     = $clog2(SensorCount + 1);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_GROUP = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] REG_TOLERANCE = 2'd0;
   localparam logic [1:0] REG_MIN_COUNT = 2'd1;
   localparam logic [1:0] REG_MASK      = 2'd2;

   localparam logic [31:0] TOLERANCE_RESET = 32'd10000;
   localparam logic [4:0]  MIN_COUNT_RESET = 5'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_DONE,
      ST_ANCHOR_SCAN,
      ST_ANCHOR_DONE,
      ST_PICK_SCAN,
      ST_PICK_DONE,
      ST_EMIT,
      ST_REMOVE_SCAN,
      ST_NOT_FOUND
   } state_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  out_sensor;
      logic [31:0] out_stamp;
      logic [31:0] out_handle;
      logic        last;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] stamp;
      logic [3:0]  sensor;
      logic [31:0] handle;
   } req_type;
endpackage

[rtl/tgs_if.sv]
`timescale 1ns / 1ps
interface tgs_req_if
   import tgs_pkg::*;
();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tgs_rsp_if
   import tgs_pkg::*;
();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/tgs_table.sv]
`timescale 1ns / 1ps
module tgs_table
   import tgs_pkg::*;
(
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  logic [31:0]     wr_stamp,
   input  logic [3:0]      wr_sensor,
   input  logic [31:0]     wr_handle,
   input  logic [IdxW-1:0] rd_addr,
   output logic [31:0]     rd_stamp,
   output logic [3:0]      rd_sensor,
   output logic [31:0]     rd_handle
);
   logic [67:0] mem [TableDepth];
   logic [67:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_stamp, wr_sensor, wr_handle};
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_stamp  = rd_ff[67:36];
   assign rd_sensor = rd_ff[35:32];
   assign rd_handle = rd_ff[31:0];
endmodule

[rtl/tgs_cmp.sv]
`timescale 1ns / 1ps
// shared distance unit: a>b flag, |a-b| and its compare against tolerance
module tgs_cmp (
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] tol,
   output logic        a_gt_b,
   output logic        in_tol
);
   logic [32:0] diff;
   logic [31:0] gap;
   always_comb begin
      diff   = {1'b0, a} - {1'b0, b};
      a_gt_b = !diff[32] && (diff[31:0] != 32'd0);
      gap    = diff[32] ? (b - a) : diff[31:0];
      in_tol = gap <= tol;
   end
endmodule

[rtl/timestamp_group_synchronizer_unit.sv]
`timescale 1ns / 1ps
// Add: one sweep of the table (one table read per cycle), then the write; clear acts on acceptance.
// Group request: per anchor two sweeps (anchor scan, pick scan), then one beat per member
// and a removal sweep, all through one read port.
// Throughput: one request at a time; req_ready is low while a request is being worked.
// Reset (synchronous, active high): table empty, overflow clear, registers at defaults.
module timestamp_group_synchronizer_unit
   import tgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tgs_req_if.sink     req,
   tgs_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   state_type state_ff, state_in;

   logic [31:0] tol_ff;
   logic [4:0]  min_ff;
   logic [15:0] mask_ff;
   logic        ovf_ff, ovf_in;
   logic [TableDepth-1:0] valid_ff, valid_in;

   req_type     cur_ff, cur_in;
   logic [CntW-1:0] scan_ff, scan_in;   // read address counter
   logic        rv_ff, rv_in;            // read data valid this cycle
   logic [IdxW-1:0] ridx_ff, ridx_in;    // address of data on read port
   logic        hit_ff, hit_in;
   logic        free_ok_ff, free_ok_in;
   logic [IdxW-1:0] free_ff, free_in;
   logic [IdxW-1:0] hitidx_ff, hitidx_in;
   logic        have_prev_ff, have_prev_in;
   logic [31:0] anchor_ff, anchor_in;
   logic        got_ff, got_in;
   logic [31:0] next_ff, next_in;
   logic [SensorCount-1:0] pv_ff, pv_in;
   logic [31:0] ps_ff [SensorCount];
   logic [31:0] ps_in [SensorCount];
   logic [31:0] ph_ff [SensorCount];
   logic [31:0] ph_in [SensorCount];
   logic [SenW-1:0] es_ff, es_in;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;

   logic        wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;
   logic [31:0] rd_stamp, rd_handle;
   logic [3:0]  rd_sensor;
   logic [31:0] cmp_a, cmp_b;
   logic        cmp_gt, cmp_within;
   logic        scan_end;
   logic [SenCntW-1:0] cnt;
   logic        complete;
   logic        more;
   logic [SenW-1:0] nxt_s;

   tgs_table u_table (
      .clock, .wr_en, .wr_addr,
      .wr_stamp(cur_ff.stamp), .wr_sensor(cur_ff.sensor), .wr_handle(cur_ff.handle),
      .rd_addr, .rd_stamp, .rd_sensor, .rd_handle
   );

   tgs_cmp u_cmp (.a(cmp_a), .b(cmp_b), .tol(tol_ff), .a_gt_b(cmp_gt), .in_tol(cmp_within));

   assign rd_addr  = scan_ff[IdxW-1:0];
   assign scan_end = scan_ff == CntW'(TableDepth);
   assign req.ready = (state_ff == ST_IDLE) && !ov_ff;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      cnt = '0;
      for (int s = 0; s < SensorCount; s++) cnt = cnt + SenCntW'(pv_ff[s]);
      if (mask_ff == 16'd0)
         complete = (5'(cnt) >= min_ff) && (cnt != '0);
      else
         complete = (pv_ff & mask_ff) == mask_ff;
      more  = 1'b0;
      nxt_s = '0;
      for (int s = SensorCount - 1; s >= 0; s--) begin
         if (SenW'(s) > es_ff && pv_ff[s]) begin
            more  = 1'b1;
            nxt_s = SenW'(s);
         end
      end
   end

   // compare operand selection
   always_comb begin
      cmp_a = rd_stamp;
      cmp_b = anchor_ff;
      case (state_ff)
         ST_ANCHOR_SCAN: begin
            // gt flags a stamp below the current candidate
            cmp_a = next_ff;
            cmp_b = rd_stamp;
         end
         default: begin
            cmp_a = rd_stamp;
            cmp_b = anchor_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               case (req.payload.op)
                  OP_ADD:   state_in = ST_ADD_SCAN;
                  OP_GROUP: state_in = ST_ANCHOR_SCAN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_SCAN:    if (!rv_ff && scan_end) state_in = ST_ADD_DONE;
         ST_ADD_DONE:    state_in = ST_IDLE;
         ST_ANCHOR_SCAN: if (!rv_ff && scan_end) state_in = ST_ANCHOR_DONE;
         ST_ANCHOR_DONE: state_in = got_ff ? ST_PICK_SCAN : ST_NOT_FOUND;
         ST_PICK_SCAN:   if (!rv_ff && scan_end) state_in = ST_PICK_DONE;
         ST_PICK_DONE:   state_in = complete ? ST_EMIT : ST_ANCHOR_SCAN;
         ST_EMIT:        if (!ov_ff && !more) state_in = ST_REMOVE_SCAN;
         ST_REMOVE_SCAN: if (!rv_ff && scan_end) state_in = ST_IDLE;
         ST_NOT_FOUND:   if (!ov_ff) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cur_in = cur_ff;   scan_in = scan_ff;   rv_in = 1'b0;   ridx_in = rd_addr;
      hit_in = hit_ff;   free_ok_in = free_ok_ff;   free_in = free_ff;
      hitidx_in = hitidx_ff;   have_prev_in = have_prev_ff;   anchor_in = anchor_ff;
      got_in = got_ff;   next_in = next_ff;   pv_in = pv_ff;   es_in = es_ff;
      ps_in = ps_ff;   ph_in = ph_ff;
      out_in = out_ff;   ov_in = ov_ff;   ovf_in = ovf_ff;   valid_in = valid_ff;
      wr_en = 1'b0;   wr_addr = free_ff;

      if (ov_ff && rsp.ready) ov_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;   hit_in = 1'b0;   free_ok_in = 1'b0;
            have_prev_in = 1'b0;   got_in = 1'b0;
            if (req.valid && req.ready) begin
               cur_in = req.payload;
               if (req.payload.op == OP_CLEAR) begin
                  valid_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         ST_ADD_SCAN, ST_ANCHOR_SCAN, ST_PICK_SCAN, ST_REMOVE_SCAN: begin
            if (!scan_end) begin
               scan_in = scan_ff + 1'b1;
               rv_in   = 1'b1;
            end
            if (rv_ff && valid_ff[ridx_ff]) begin
               case (state_ff)
                  ST_ADD_SCAN:
                     if (rd_stamp == cur_ff.stamp && rd_sensor == cur_ff.sensor
                         && !hit_ff) begin
                        hit_in = 1'b1;   hitidx_in = ridx_ff;
                     end
                  ST_ANCHOR_SCAN:
                     if (!(have_prev_ff && !(rd_stamp > anchor_ff))
                         && (!got_ff || cmp_gt)) begin
                        got_in = 1'b1;   next_in = rd_stamp;
                     end
                  ST_PICK_SCAN:
                     if (cmp_within) begin
                        if (!pv_ff[rd_sensor] || rd_stamp > ps_ff[rd_sensor]) begin
                           pv_in[rd_sensor] = 1'b1;
                           ps_in[rd_sensor] = rd_stamp;
                           ph_in[rd_sensor] = rd_handle;
                        end
                     end
                  default:
                     if (cmp_within) valid_in[ridx_ff] = 1'b0;
               endcase
            end
            if (state_ff == ST_ADD_SCAN && rv_ff && !valid_ff[ridx_ff] && !free_ok_ff) begin
               free_ok_in = 1'b1;   free_in = ridx_ff;
            end
         end
         ST_ADD_DONE: begin
            if (hit_ff) begin
               wr_en = 1'b1;   wr_addr = hitidx_ff;
            end else if (free_ok_ff) begin
               wr_en = 1'b1;   wr_addr = free_ff;   valid_in[free_ff] = 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
         end
         ST_ANCHOR_DONE: begin
            anchor_in = next_ff;   have_prev_in = 1'b1;   got_in = 1'b0;
            scan_in = '0;   pv_in = '0;
         end
         ST_PICK_DONE: begin
            scan_in = '0;   es_in = '0;
            for (int s = SensorCount - 1; s >= 0; s--)
               if (pv_ff[s]) es_in = SenW'(s);
         end
         ST_EMIT: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               out_in.found = 1'b1;
               out_in.out_sensor = es_ff;
               out_in.out_stamp  = ps_ff[es_ff];
               out_in.out_handle = ph_ff[es_ff];
               out_in.last = !more;
               out_in.overflow = ovf_ff;
               es_in = nxt_s;
            end
         end
         ST_NOT_FOUND: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               out_in = '{found: 1'b0, out_sensor: 4'd0, out_stamp: 32'd0,
                          out_handle: 32'd0, last: 1'b1, overflow: ovf_ff};
            end
         end
         default: ;
      endcase
   end

   // wr_en for group/scan states is held low, keep add payload for writes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tol_ff   <= TOLERANCE_RESET;
         min_ff   <= MIN_COUNT_RESET;
         mask_ff  <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= '0;
         ov_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
         ov_ff    <= ov_in;
         rv_ff    <= rv_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_TOLERANCE: tol_ff  <= csr_write_data;
               REG_MIN_COUNT: min_ff  <= csr_write_data[4:0];
               REG_MASK:      mask_ff <= csr_write_data[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;   scan_ff <= scan_in;   ridx_ff <= ridx_in;
      hit_ff <= hit_in;   free_ok_ff <= free_ok_in;   free_ff <= free_in;
      hitidx_ff <= hitidx_in;   have_prev_ff <= have_prev_in;   anchor_ff <= anchor_in;
      got_ff <= got_in;   next_ff <= next_in;   pv_ff <= pv_in;   es_ff <= es_in;
      ps_ff <= ps_in;   ph_ff <= ph_in;   out_ff <= out_in;
   end

`ifndef NO_ASSERTIONS
   // a beat is only held in the emit, not-found, remove-scan or idle states
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (state_ff == ST_EMIT || state_ff == ST_NOT_FOUND
                     || state_ff == ST_REMOVE_SCAN || state_ff == ST_IDLE))
      else $error("result beat outside emit");
   // no new request while a result is held
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken with result pending");
   // clear empties the table and clears overflow
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.payload.op == OP_CLEAR) |=> (valid_ff == '0 && !ovf_ff))
      else $error("clear left entries");
`endif
endmodule
